/* src/percent_tag_to_ansi_expander_defines.svh */
`ifndef PERCENT_TAG_TO_ANSI_EXPANDER_DEFINES_SVH
`define PERCENT_TAG_TO_ANSI_EXPANDER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pte assertion failed");

// Next-cycle implication, disabled in reset.
`define PTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pte assertion failed");

`endif

/* src/pte_pkg.sv */
`timescale 1ns / 1ps

package pte_pkg;

   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_ESC      = 8'h1B;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_ONE      = 8'h31;
   localparam logic [7:0] CHAR_THREE    = 8'h33;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_M  = 8'h6D;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;

   localparam int unsigned ESC_LEN = 7;
   localparam int unsigned ESC_IDX_W = $clog2(ESC_LEN);

   // Byte positions within an escape sequence.
   localparam logic [ESC_IDX_W-1:0] ESC_POS_ESC    = ESC_IDX_W'(0);
   localparam logic [ESC_IDX_W-1:0] ESC_POS_BRACK  = ESC_IDX_W'(1);
   localparam logic [ESC_IDX_W-1:0] ESC_POS_BOLD   = ESC_IDX_W'(2);
   localparam logic [ESC_IDX_W-1:0] ESC_POS_SEMI   = ESC_IDX_W'(3);
   localparam logic [ESC_IDX_W-1:0] ESC_POS_THREE  = ESC_IDX_W'(4);
   localparam logic [ESC_IDX_W-1:0] ESC_POS_DIGIT  = ESC_IDX_W'(5);
   localparam logic [ESC_IDX_W-1:0] ESC_POS_FINAL  = ESC_IDX_W'(6);

   typedef struct packed {
      logic       hit;
      logic [2:0] digit;
   } colour_type;

   // One unit of output work: a single byte or a full escape sequence.
   typedef struct packed {
      logic       esc;
      logic       bold;
      logic [2:0] digit;
      logic [7:0] data;
   } job_type;

   // Letter offset 0..25 to colour digit.
   function automatic colour_type colour_lookup(input logic [4:0] idx);
      colour_type c;
      c.hit   = 1'b1;
      c.digit = 3'd0;
      case (idx)
         5'd1:  c.digit = 3'd4;  // B
         5'd2:  c.digit = 3'd6;  // C
         5'd6:  c.digit = 3'd2;  // G
         5'd10: c.digit = 3'd0;  // K
         5'd12: c.digit = 3'd5;  // M
         5'd17: c.digit = 3'd1;  // R
         5'd22: c.digit = 3'd7;  // W
         5'd24: c.digit = 3'd3;  // Y
         default: c.hit = 1'b0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] esc_byte(input logic [ESC_IDX_W-1:0] pos,
                                           input logic bold,
                                           input logic [2:0] digit);
      logic [7:0] b;
      case (pos)
         ESC_POS_ESC:   b = CHAR_ESC;
         ESC_POS_BRACK: b = CHAR_LBRACKET;
         ESC_POS_BOLD:  b = bold ? CHAR_ONE : CHAR_ZERO;
         ESC_POS_SEMI:  b = CHAR_SEMI;
         ESC_POS_THREE: b = CHAR_THREE;
         ESC_POS_DIGIT: b = CHAR_ZERO | {5'd0, digit};
         ESC_POS_FINAL: b = CHAR_LOWER_M;
         default:       b = CHAR_NUL;
      endcase
      return b;
   endfunction

endpackage

/* src/pte_flag_mem.sv */
`timescale 1ns / 1ps

module pte_flag_mem (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic wr_en,
   input  logic wr_data,
   output logic rd_data
);
   logic flag_mem_ff [1];
   logic valid_ff;
   logic valid_in;
   logic rd_data_ff;

   assign valid_in = valid_ff | wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         flag_mem_ff[0] <= wr_data;
      end
   end

   // Read during write returns the new value; an unwritten entry reads as clear.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= valid_ff & flag_mem_ff[0];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pte_emitter.sv */
`timescale 1ns / 1ps
`include "percent_tag_to_ansi_expander_defines.svh"

module pte_emitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  pte_pkg::job_type job,
   output logic             job_take,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);
   import pte_pkg::*;

   logic                 busy_ff, busy_in;
   job_type              job_ff, job_in;
   logic [ESC_IDX_W-1:0] idx_ff, idx_in;
   logic                 beat;
   logic                 last;

   assign beat     = busy_ff & rsp_tready;
   assign last     = ~job_ff.esc | (idx_ff == ESC_POS_FINAL);
   assign job_take = ~busy_ff | (beat & last);

   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      idx_in  = idx_ff;
      if (job_take) begin
         busy_in = job_valid;
         job_in  = job;
         idx_in  = '0;
      end else if (beat) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = job_ff.esc ? esc_byte(idx_ff, job_ff.bold, job_ff.digit) : job_ff.data;
   assign rsp_tlast  = last;

   `PTE_ASSERT_NOW(a_plain_at_zero, clock, reset, busy_ff && !job_ff.esc, idx_ff == '0)
   `PTE_ASSERT_NEXT(a_esc_holds, clock, reset, beat && !last, busy_ff && job_ff.esc)
   `PTE_ASSERT_NEXT(a_stall_holds_idx, clock, reset, busy_ff && !rsp_tready,
                    idx_ff == $past(idx_ff) && busy_ff)
   `PTE_ASSERT_NOW(a_idx_in_range, clock, reset, busy_ff, idx_ff <= ESC_POS_FINAL)

endmodule

/* src/percent_tag_to_ansi_expander.sv */
`timescale 1ns / 1ps
// Rewrites percent tags in a byte stream into ANSI colour escapes. Plain bytes
// flow at one per cycle while rsp_tready stays high, registered in the input
// stage and then the output stage; a colour tag such as "%R" produces seven
// one-byte output beats and can hold req_tready low. The pending-percent flag
// sits in a one-entry memory read at accept and written back when the byte is
// decoded, with read-during-write forwarding. csr_wr_data sets whether bytes
// 128..255 pass (1) or are dropped (0); write it only while the block is idle.
// rsp_tlast marks the last output byte caused by one input byte.

module percent_tag_to_ansi_expander (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic       rsp_tlast,   // run_last
   input  logic       csr_wr_en,
   input  logic       csr_wr_data  // keep_high_bytes
);
   import pte_pkg::*;

   logic       keep_ff, keep_in;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       req_beat;
   logic       s1_adv;
   logic       pending;
   logic       flag_next;
   logic       emit;
   job_type    job;
   logic       job_take;
   colour_type col_up, col_lo;
   logic [4:0] upper_off, lower_off;

   assign keep_in = csr_wr_en ? csr_wr_data : keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         keep_ff     <= keep_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_char_ff <= req_tdata;
      end
   end

   assign s1_adv      = s1_valid_ff & (~emit | job_take);
   assign req_tready  = ~s1_valid_ff | s1_adv;
   assign req_beat    = req_tvalid & req_tready;
   assign s1_valid_in = req_beat | (s1_valid_ff & ~s1_adv);

   pte_flag_mem u_flag_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_beat),
      .wr_en   (s1_adv),
      .wr_data (flag_next),
      .rd_data (pending)
   );

   // Letter offset only needs the low five bits; the range checks below gate it.
   assign upper_off = s1_char_ff[4:0] - CHAR_UPPER_A[4:0];
   assign lower_off = s1_char_ff[4:0] - CHAR_LOWER_A[4:0];
   assign col_up    = colour_lookup(upper_off);
   assign col_lo    = colour_lookup(lower_off);

   always_comb begin
      emit      = 1'b0;
      flag_next = 1'b0;
      job       = '0;
      if (s1_char_ff == CHAR_NUL) begin
         emit     = 1'b1;
         job.data = CHAR_NUL;
      end else if (pending) begin
         if (s1_char_ff == CHAR_PERCENT) begin
            emit     = 1'b1;
            job.data = CHAR_PERCENT;
         end else if (s1_char_ff >= CHAR_UPPER_A && s1_char_ff <= CHAR_UPPER_Z) begin
            emit      = col_up.hit;
            job.esc   = 1'b1;
            job.bold  = 1'b1;
            job.digit = col_up.digit;
         end else if (s1_char_ff >= CHAR_LOWER_A && s1_char_ff <= CHAR_LOWER_Z) begin
            emit      = col_lo.hit;
            job.esc   = 1'b1;
            job.digit = col_lo.digit;
         end
      end else if (s1_char_ff == CHAR_PERCENT) begin
         flag_next = 1'b1;
      end else if (s1_char_ff < CHAR_SPACE) begin
         emit = 1'b0;
      end else if (s1_char_ff[7] && !keep_ff) begin
         emit = 1'b0;
      end else begin
         emit     = 1'b1;
         job.data = s1_char_ff;
      end
   end

   pte_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (s1_valid_ff & emit),
      .job        (job),
      .job_take   (job_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
